[hw/rtl/edfq_pkg.sv]
// Shared types and constants for the EDF ready queue.
package edfq_pkg;

	localparam int unsigned QueueDepthDefault = 16;
	localparam int unsigned TaskW = 15;
	localparam int unsigned RelW  = 40;
	localparam int unsigned NowW  = 62;
	localparam int unsigned DlW   = 63;

	typedef enum logic [1:0] {
		OP_ENQ   = 2'd0,
		OP_DEQ   = 2'd1,
		OP_CHECK = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_RSVD     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		POL_NORMAL   = 3'd0,
		POL_BATCH    = 3'd1,
		POL_IDLE     = 3'd2,
		POL_FIFO     = 3'd3,
		POL_RR       = 3'd4,
		POL_DEADLINE = 3'd5,
		POL_EDF      = 3'd6,
		POL_OTHER    = 3'd7
	} policy_t;

	// One queue entry
	typedef struct packed {
		logic             valid;
		logic [TaskW-1:0] task_id;
		logic [DlW-1:0]   deadline;
	} slot_t;

	// Hand-off from a cell to its right neighbor
	typedef struct packed {
		slot_t slot;
		logic  ahead;  // entry stays ahead of the new deadline
		logic  found;  // dequeue id matched here or further left
	} link_t;

	// Command broadcast to every cell
	typedef struct packed {
		logic             en;
		op_t              op;
		logic             full;
		logic [TaskW-1:0] task_id;
		logic [DlW-1:0]   deadline;
	} cmd_t;

endpackage

[hw/rtl/edfq_cell.sv]
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
module edfq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  edfq_pkg::cmd_t  cmd,
	input  edfq_pkg::link_t left,
	input  edfq_pkg::slot_t right,
	output edfq_pkg::link_t to_right,
	output edfq_pkg::slot_t own
);
	import edfq_pkg::*;

	logic  valid_q;
	logic [TaskW-1:0] task_q;
	logic [DlW-1:0] dl_q;
	slot_t next;
	logic  ahead;
	logic  found;

	// Compare against the broadcast command
	always_comb begin
		ahead = valid_q && (dl_q <= cmd.deadline);
		found = left.found | (valid_q && (task_q == cmd.task_id));
		next = '{valid: valid_q, task_id: task_q, deadline: dl_q};
		case (cmd.op)
			OP_ENQ: begin
				// insert here, or shift right by taking the left entry
				if (cmd.en && !cmd.full && !ahead) begin
					if (left.ahead) begin
						next = '{valid: 1'b1, task_id: cmd.task_id, deadline: cmd.deadline};
					end else begin
						next = left.slot;
					end
				end
			end
			OP_DEQ: begin
				// close the gap by taking the right entry
				if (cmd.en && found) begin
					next = right;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= next.valid;
		end
	end

	// Hold payload
	always_ff @(posedge clk) begin
		task_q <= next.task_id;
		dl_q   <= next.deadline;
	end

	assign own = '{valid: valid_q, task_id: task_q, deadline: dl_q};
	assign to_right = '{slot: own, ahead: ahead, found: found};

endmodule

[hw/rtl/edf_ready_queue.sv]
// Top level of the earliest-deadline-first ready queue built as a chain of cells.
//
// Usage: drive opcode and its operands and raise start; a command transfers at a
// rising edge with start high and busy low. busy stays low, so a command may be
// given in every cycle. Enqueue stores now_ns + relative_deadline in deadline
// order behind equal deadlines; dequeue removes the entry with task_id nearest
// the head; a preemption check evaluates current_policy and current_task_id
// against the head.
// The result appears in the cycle after the transfer, marked by done, which is
// high for a single cycle. Throughput: one command per cycle.
// Every cell compares its entry to the broadcast command and shifts with its
// neighbors in the same cycle; the dequeue match flag ripples along the chain.
// The result reports the head as it stands after the command, plus resched and
// status (queue full on enqueue, id not found on dequeue).
// Reset clears all valid bits, so the queue starts empty and done is low.
// The receiver cannot stall: each result must be taken in its cycle.
module edf_ready_queue #(
	parameter int unsigned QUEUE_DEPTH = edfq_pkg::QueueDepthDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 opcode,
	input  logic [edfq_pkg::TaskW-1:0] task_id,
	input  logic [edfq_pkg::RelW-1:0]  relative_deadline,
	input  logic [edfq_pkg::NowW-1:0]  now_ns,
	input  logic [2:0]                 current_policy,
	input  logic [edfq_pkg::TaskW-1:0] current_task_id,
	output logic                       done,
	output logic                       head_valid,
	output logic [edfq_pkg::TaskW-1:0] head_task_id,
	output logic [edfq_pkg::DlW-1:0]   head_deadline,
	output logic                       resched,
	output logic [1:0]                 status
);
	import edfq_pkg::*;

	cmd_t    cmd;
	link_t   lnk [QUEUE_DEPTH+1];
	slot_t   sl  [QUEUE_DEPTH+1];
	policy_t pol;
	logic    resched_d;
	status_t status_d;
	logic    done_q;
	logic    resched_q;
	status_t status_q;

	// Build the broadcast command
	always_comb begin
		cmd.en       = start && !busy;
		cmd.op       = op_t'(opcode);
		cmd.full     = sl[QUEUE_DEPTH-1].valid;
		cmd.task_id  = task_id;
		cmd.deadline = {1'b0, now_ns} + {{(DlW-RelW){1'b0}}, relative_deadline};
	end

	// Tie off the chain ends: the head sees everything ahead, the tail sees empty
	assign lnk[0] = '{slot: '{valid: 1'b0, task_id: '0, deadline: '0},
		ahead: 1'b1, found: 1'b0};
	assign sl[QUEUE_DEPTH] = '{valid: 1'b0, task_id: '0, deadline: '0};

	// Chain of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		edfq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.left     (lnk[i]),
			.right    (sl[i+1]),
			.to_right (lnk[i+1]),
			.own      (sl[i])
		);
	end

	// Decide rescheduling and status from the state before the update
	always_comb begin
		pol = policy_t'(current_policy);
		resched_d = 1'b0;
		status_d = ST_OK;
		case (cmd.op)
			OP_ENQ: begin
				if (cmd.full) begin
					status_d = ST_FULL;
				end
			end
			OP_DEQ: begin
				if (!lnk[QUEUE_DEPTH].found) begin
					status_d = ST_NOTFOUND;
				end
			end
			OP_CHECK: begin
				if (pol inside {POL_NORMAL, POL_BATCH, POL_IDLE}) begin
					resched_d = 1'b1;
				end else if (pol == POL_EDF) begin
					resched_d = !sl[0].valid || (sl[0].task_id != current_task_id);
				end
			end
			default: begin
			end
		endcase
	end

	// Register the result strobe and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			resched_q <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			done_q <= cmd.en;
			if (cmd.en) begin
				resched_q <= resched_d;
				status_q  <= status_d;
			end
		end
	end

	assign busy          = 1'b0;
	assign done          = done_q;
	assign resched       = resched_q;
	assign status        = status_q;
	assign head_valid    = sl[0].valid;
	assign head_task_id  = sl[0].valid ? sl[0].task_id : '0;
	assign head_deadline = sl[0].valid ? sl[0].deadline : '0;

endmodule
